/* hw/rtl/ppmfd_pkg.sv */
package ppmfd_pkg;

  localparam int unsigned MaxChannels = 16;
  localparam int unsigned ValW        = 16;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned ChanW       = 4;
  localparam int unsigned PosW        = 5;
  localparam int unsigned StatW       = 3;
  localparam int unsigned CfgIdxW     = 3;

  localparam logic [ValW-1:0] SyncGapRst  = 16'd3000;
  localparam logic [ValW-1:0] MinPulseRst = 16'd700;
  localparam logic [ValW-1:0] MaxPulseRst = 16'd2300;
  localparam logic [ValW-1:0] ValidLoRst  = 16'd900;
  localparam logic [ValW-1:0] ValidHiRst  = 16'd2100;
  localparam logic [ValW-1:0] DefaultRst  = 16'd1500;
  localparam logic [ValW-1:0] StoreRst    = 16'd1500;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [StatW-1:0] ST_READ     = 3'd0;
  localparam logic [StatW-1:0] ST_STORED   = 3'd1;
  localparam logic [StatW-1:0] ST_SYNC     = 3'd2;
  localparam logic [StatW-1:0] ST_RANGE    = 3'd3;
  localparam logic [StatW-1:0] ST_FULL     = 3'd4;
  localparam logic [StatW-1:0] ST_IGNORED  = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SYNC_GAP  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_PULSE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_PULSE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_VALID_LO  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VALID_HI  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DEFAULT   = 3'd6;

  typedef struct packed {
    logic            enable;
    logic [ValW-1:0] sync_gap;
    logic [ValW-1:0] min_pulse;
    logic [ValW-1:0] max_pulse;
    logic [ValW-1:0] valid_lo;
    logic [ValW-1:0] valid_hi;
    logic [ValW-1:0] dflt;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [ChanW-1:0] addr;
    logic [ValW-1:0]  data;
  } store_wr_t;

  typedef struct packed {
    logic [ValW-1:0]  value;
    logic [StatW-1:0] status;
    logic [PosW-1:0]  pos;
  } result_t;

endpackage

/* hw/rtl/ppm_frame_decoder_core.sv */
// PPM frame decoder.
// Input channel: in_cmd selects an edge beat (timestamp in in_edge_time_us)
// or a read beat (slot in in_read_channel). Every input beat yields exactly
// one result beat on the out_ channel, in order.
// Config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready;
// cfg_ready is always high. Write only while no beat is in flight.
// Path: a beat accepted on in_ passes through the input register, then is
// decoded into the result register that drives out_.
// Throughput: one beat per cycle while out_stall is low; decode, interval
// compare and slot write all happen between the two registers, with no other register in the path.
// Stall: out_stall holds the result register; the input register keeps its
// beat and in_stall rises only when both registers are full.
// Reset: sync, active low. Decoder disabled, frame position and time
// reference cleared, all slots read as 1500, thresholds at defaults.
module ppm_frame_decoder_core #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [ppmfd_pkg::TimeW-1:0]    in_edge_time_us,
  input  logic [ppmfd_pkg::ChanW-1:0]    in_read_channel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ppmfd_pkg::ValW-1:0]     out_channel_value_us,
  output logic [ppmfd_pkg::StatW-1:0]    out_edge_status,
  output logic [ppmfd_pkg::PosW-1:0]     out_frame_position,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppmfd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ppmfd_pkg::ValW-1:0]     cfg_data
);
  import ppmfd_pkg::*;

  cfg_t      cfg;
  logic      restart;
  store_wr_t store_wr;
  logic [ChanW-1:0] store_rd_addr;
  logic [ValW-1:0]  store_rd_data;
  result_t   result;

  logic             s1_valid_r;
  logic             cmd_r;
  logic [TimeW-1:0] time_r;
  logic [ChanW-1:0] chan_r;
  logic             out_valid_r;
  result_t          out_r;

  logic advance;
  logic fire;
  logic in_acc;

  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  ppmfd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .restart  (restart)
  );

  ppmfd_store #(.CHANNELS(CHANNELS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (store_wr),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data)
  );

  ppmfd_decode #(.CHANNELS(CHANNELS)) u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .restart       (restart),
    .fire          (fire),
    .cmd           (cmd_r),
    .edge_time     (time_r),
    .read_channel  (chan_r),
    .store_rd_data (store_rd_data),
    .store_rd_addr (store_rd_addr),
    .store_wr      (store_wr),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_cmd;
      time_r <= in_edge_time_us;
      chan_r <= in_read_channel;
    end
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_channel_value_us = out_r.value;
  assign out_edge_status      = out_r.status;
  assign out_frame_position   = out_r.pos;

endmodule

/* hw/rtl/ppmfd_cfg.sv */
module ppmfd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [ppmfd_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [ppmfd_pkg::ValW-1:0]      wr_data,
  output ppmfd_pkg::cfg_t                 cfg,
  output logic                            restart
);
  import ppmfd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic restart_nxt;

  always_comb begin
    cfg_nxt     = cfg_r;
    restart_nxt = 1'b0;
    if (wr_en) begin
      case (wr_index)
        REG_ENABLE: begin
          cfg_nxt.enable = wr_data[0];
          restart_nxt    = wr_data[0] != cfg_r.enable;
        end
        REG_SYNC_GAP:  cfg_nxt.sync_gap  = wr_data;
        REG_MIN_PULSE: cfg_nxt.min_pulse = wr_data;
        REG_MAX_PULSE: cfg_nxt.max_pulse = wr_data;
        REG_VALID_LO:  cfg_nxt.valid_lo  = wr_data;
        REG_VALID_HI:  cfg_nxt.valid_hi  = wr_data;
        REG_DEFAULT:   cfg_nxt.dflt      = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b0;
      cfg_r.sync_gap  <= SyncGapRst;
      cfg_r.min_pulse <= MinPulseRst;
      cfg_r.max_pulse <= MaxPulseRst;
      cfg_r.valid_lo  <= ValidLoRst;
      cfg_r.valid_hi  <= ValidHiRst;
      cfg_r.dflt      <= DefaultRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign restart = restart_nxt;

endmodule

/* hw/rtl/ppmfd_store.sv */
module ppmfd_store #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppmfd_pkg::store_wr_t          wr,
  input  logic [ppmfd_pkg::ChanW-1:0]   rd_addr,
  output logic [ppmfd_pkg::ValW-1:0]    rd_data
);
  import ppmfd_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [ValW-1:0]     entry_r [CHANNELS];
  logic [CHANNELS-1:0] vld_r;
  logic [IdxW-1:0]     wa;
  logic [IdxW-1:0]     ra;

  assign wa = wr.addr[IdxW-1:0];
  assign ra = rd_addr[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      entry_r[wa] <= wr.data;
    end
  end

  // unwritten slots read as their reset value
  assign rd_data = vld_r[ra] ? entry_r[ra] : StoreRst;

endmodule

/* hw/rtl/ppmfd_decode.sv */
module ppmfd_decode #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppmfd_pkg::cfg_t               cfg,
  input  logic                          restart,
  input  logic                          fire,
  input  logic                          cmd,
  input  logic [ppmfd_pkg::TimeW-1:0]   edge_time,
  input  logic [ppmfd_pkg::ChanW-1:0]   read_channel,
  input  logic [ppmfd_pkg::ValW-1:0]    store_rd_data,
  output logic [ppmfd_pkg::ChanW-1:0]   store_rd_addr,
  output ppmfd_pkg::store_wr_t          store_wr,
  output ppmfd_pkg::result_t            result
);
  import ppmfd_pkg::*;

  localparam logic [PosW-1:0] ChanLim = PosW'(CHANNELS);

  logic [PosW-1:0]  slot_r, slot_nxt;
  logic [TimeW-1:0] last_r, last_nxt;
  logic             ref_r, ref_nxt;

  logic [TimeW-1:0] dt;
  logic             in_frame;
  logic             in_window;
  logic             is_sync;
  logic             is_pulse;

  assign dt        = edge_time - last_r;
  assign is_sync   = dt > TimeW'(cfg.sync_gap);
  assign is_pulse  = (dt >= TimeW'(cfg.min_pulse)) && (dt <= TimeW'(cfg.max_pulse));
  assign in_frame  = {1'b0, read_channel} < ChanLim;
  assign in_window = (store_rd_data >= cfg.valid_lo) && (store_rd_data <= cfg.valid_hi);
  assign store_rd_addr = read_channel;

  always_comb begin
    slot_nxt      = slot_r;
    last_nxt      = last_r;
    ref_nxt       = ref_r;
    store_wr.en   = 1'b0;
    store_wr.addr = slot_r[ChanW-1:0];
    store_wr.data = dt[ValW-1:0];
    result.value  = '0;
    result.status = ST_IGNORED;

    if (cmd == CMD_READ) begin
      result.status = ST_READ;
      result.value  = (in_frame && in_window) ? store_rd_data : cfg.dflt;
    end else if (!cfg.enable) begin
      result.status = ST_IGNORED;
    end else if (!ref_r) begin
      last_nxt      = edge_time;
      ref_nxt       = 1'b1;
      result.status = ST_IGNORED;
    end else begin
      last_nxt = edge_time;
      if (is_sync) begin
        slot_nxt      = '0;
        result.status = ST_SYNC;
      end else if (!is_pulse) begin
        result.status = ST_RANGE;
      end else if (slot_r < ChanLim) begin
        store_wr.en   = fire;
        slot_nxt      = slot_r + PosW'(1);
        result.status = ST_STORED;
      end else begin
        result.status = ST_FULL;
      end
    end
    result.pos = slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      last_r <= '0;
      ref_r  <= 1'b0;
    end else if (restart) begin
      slot_r <= '0;
      ref_r  <= 1'b0;
    end else if (fire) begin
      slot_r <= slot_nxt;
      last_r <= last_nxt;
      ref_r  <= ref_nxt;
    end
  end

endmodule

/* hw/rtl/ppmfd_checker.sv */
module ppmfd_checker #(
  parameter int unsigned CHANNELS = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ppmfd_pkg::ValW-1:0]     out_channel_value_us,
  input logic [ppmfd_pkg::StatW-1:0]    out_edge_status,
  input logic [ppmfd_pkg::PosW-1:0]     out_frame_position
);
  import ppmfd_pkg::*;

  localparam logic [PosW-1:0] ChanLim = PosW'(CHANNELS);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel_value_us)
      && $stable(out_edge_status) && $stable(out_frame_position))
    else $error("result changed while stalled");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_position <= ChanLim)
    else $error("frame position beyond channel count");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_edge_status <= ST_IGNORED)
    else $error("undefined edge status");

  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_status != ST_READ |-> out_channel_value_us == '0)
    else $error("edge beat carries a channel value");

  a_stored_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_edge_status == ST_STORED) |-> out_frame_position != '0)
    else $error("stored edge left frame position at zero");

endmodule

bind ppm_frame_decoder_core ppmfd_checker #(.CHANNELS(CHANNELS)) u_ppmfd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_channel_value_us (out_channel_value_us),
  .out_edge_status      (out_edge_status),
  .out_frame_position   (out_frame_position)
);
